/* sv/ckre_pkg.sv */
package ckre_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int COL_W = $clog2(MAX_DIMENSION);
  localparam int DIM_W = COL_W + 1;
  localparam int PIX_W = 24;
  localparam int KIND_W = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [KIND_W-1:0] KIND_RUN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BOX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_KEY = 2'd0;
  localparam logic [1:0] REG_TOL = 2'd1;
  localparam logic [1:0] REG_WIDTH = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [PIX_W-1:0] KEY_RESET = 24'h008080;
  localparam logic [PIX_W-1:0] TOL_RESET = 24'h101010;
  localparam logic [DIM_W-1:0] WIDTH_RESET = DIM_W'(256);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(256);

  typedef struct packed {
    logic [PIX_W-1:0] key_color;
    logic [PIX_W-1:0] tolerance;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } ckre_cfg_t;

  typedef struct packed {
    logic run_vld;
    logic [DIM_W-1:0] run_left;
    logic [DIM_W-1:0] run_top;
    logic [DIM_W-1:0] run_right;
    logic [DIM_W-1:0] run_bottom;
    logic frm_vld;
    logic [KIND_W-1:0] frm_kind;
    logic [DIM_W-1:0] box_left;
    logic [DIM_W-1:0] box_top;
    logic [DIM_W-1:0] box_right;
    logic [DIM_W-1:0] box_bottom;
  } ckre_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] right;
    logic [DIM_W-1:0] bottom;
    logic last;
  } ckre_rec_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end
    return r;
  endfunction

  function automatic logic byte_match(input logic [7:0] b, input logic [7:0] lo,
                                      input logic [7:0] tol);
    logic [8:0] hi;
    logic [7:0] hi_sat;
    hi = {1'b0, lo} + {1'b0, tol};
    hi_sat = hi[8] ? 8'hff : hi[7:0];
    return (b >= lo) && (b <= hi_sat);
  endfunction

endpackage

/* sv/ckre_front.sv */
module ckre_front
  import ckre_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ckre_cfg_t        cfg,
  input  logic             pix_valid,
  input  logic [PIX_W-1:0] pix,
  input  logic             q_full,
  output logic             pix_ready,
  output logic             q_push,
  output ckre_cmd_t        q_cmd
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] row_r, row_nxt;
  logic             in_run_r, in_run_nxt;
  logic [COL_W-1:0] run_start_r, run_start_nxt;
  logic             any_r, any_nxt;
  logic [DIM_W-1:0] box_l_r, box_l_nxt;
  logic [DIM_W-1:0] box_t_r, box_t_nxt;
  logic [DIM_W-1:0] box_r_r, box_r_nxt;
  logic [DIM_W-1:0] box_b_r, box_b_nxt;

  logic             clear_px;
  logic             accept;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             row_end, frame_end;
  logic             run_close, run_eol, run_vld, in_run_mid;
  logic [COL_W-1:0] start_mid;
  logic [DIM_W-1:0] run_left, run_right;
  logic             any_upd;
  logic [DIM_W-1:0] bl_upd, bt_upd, br_upd, bb_upd;

  assign pix_ready = !q_full;
  assign accept = pix_valid && pix_ready;

  always_comb begin
    clear_px = byte_match(pix[7:0], cfg.key_color[7:0], cfg.tolerance[7:0]) &&
               byte_match(pix[15:8], cfg.key_color[15:8], cfg.tolerance[15:8]) &&
               byte_match(pix[23:16], cfg.key_color[23:16], cfg.tolerance[23:16]);
    w_eff = clamp_dim(cfg.image_width);
    h_eff = clamp_dim(cfg.image_height);
    col_inc = {1'b0, col_r} + DIM_W'(1);
    row_inc = {1'b0, row_r} + DIM_W'(1);
    row_end = col_inc >= w_eff;
    frame_end = row_end && (row_inc >= h_eff);

    run_close = clear_px && in_run_r;
    in_run_mid = !clear_px;
    start_mid = (!clear_px && !in_run_r) ? col_r : run_start_r;
    run_eol = row_end && in_run_mid;
    run_vld = run_close || run_eol;
    run_left = {1'b0, start_mid};
    run_right = run_close ? {1'b0, col_r} : col_inc;

    any_upd = any_r;
    bl_upd = box_l_r;
    bt_upd = box_t_r;
    br_upd = box_r_r;
    bb_upd = box_b_r;
    if (run_vld) begin
      any_upd = 1'b1;
      if (!any_r) begin
        bl_upd = run_left;
        bt_upd = {1'b0, row_r};
        br_upd = run_right;
        bb_upd = row_inc;
      end else begin
        if (run_left < box_l_r) bl_upd = run_left;
        if ({1'b0, row_r} < box_t_r) bt_upd = {1'b0, row_r};
        if (run_right > box_r_r) br_upd = run_right;
        if (row_inc > box_b_r) bb_upd = row_inc;
      end
    end

    q_cmd.run_vld = run_vld;
    q_cmd.run_left = run_left;
    q_cmd.run_top = {1'b0, row_r};
    q_cmd.run_right = run_right;
    q_cmd.run_bottom = row_inc;
    q_cmd.frm_vld = frame_end;
    q_cmd.frm_kind = any_upd ? KIND_BOX : KIND_EMPTY;
    q_cmd.box_left = any_upd ? bl_upd : '0;
    q_cmd.box_top = any_upd ? bt_upd : '0;
    q_cmd.box_right = any_upd ? br_upd : '0;
    q_cmd.box_bottom = any_upd ? bb_upd : '0;
    q_push = accept && (run_vld || frame_end);

    col_nxt = col_r;
    row_nxt = row_r;
    in_run_nxt = in_run_r;
    run_start_nxt = run_start_r;
    any_nxt = any_r;
    box_l_nxt = box_l_r;
    box_t_nxt = box_t_r;
    box_r_nxt = box_r_r;
    box_b_nxt = box_b_r;
    if (accept) begin
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
        in_run_nxt = 1'b0;
        run_start_nxt = '0;
        any_nxt = 1'b0;
        box_l_nxt = '0;
        box_t_nxt = '0;
        box_r_nxt = '0;
        box_b_nxt = '0;
      end else begin
        col_nxt = row_end ? '0 : col_inc[COL_W-1:0];
        row_nxt = row_end ? row_inc[COL_W-1:0] : row_r;
        in_run_nxt = in_run_mid && !row_end;
        run_start_nxt = start_mid;
        any_nxt = any_upd;
        box_l_nxt = bl_upd;
        box_t_nxt = bt_upd;
        box_r_nxt = br_upd;
        box_b_nxt = bb_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      in_run_r <= 1'b0;
      run_start_r <= '0;
      any_r <= 1'b0;
      box_l_r <= '0;
      box_t_r <= '0;
      box_r_r <= '0;
      box_b_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      in_run_r <= in_run_nxt;
      run_start_r <= run_start_nxt;
      any_r <= any_nxt;
      box_l_r <= box_l_nxt;
      box_t_r <= box_t_nxt;
      box_r_r <= box_r_nxt;
      box_b_r <= box_b_nxt;
    end
  end

endmodule

/* sv/ckre_queue.sv */
module ckre_queue
  import ckre_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ckre_cmd_t push_cmd,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output ckre_cmd_t head
);

  ckre_cmd_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    count_r, count_nxt;
  logic               do_push, do_pop;

  assign full = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty = count_r == '0;
  assign head = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* sv/ckre_back.sv */
module ckre_back
  import ckre_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  ckre_cmd_t head,
  output logic      q_pop,
  input  logic      rec_ready,
  output logic      rec_valid,
  output ckre_rec_t rec
);

  logic      valid_r, valid_nxt;
  ckre_rec_t rec_r, rec_nxt;
  logic      run_sent_r, run_sent_nxt;
  logic      load;

  assign rec_valid = valid_r;
  assign rec = rec_r;

  always_comb begin
    load = !valid_r || rec_ready;
    valid_nxt = valid_r && !rec_ready;
    rec_nxt = rec_r;
    run_sent_nxt = run_sent_r;
    q_pop = 1'b0;
    if (load && !q_empty) begin
      valid_nxt = 1'b1;
      if (head.run_vld && !run_sent_r) begin
        rec_nxt.kind = KIND_RUN;
        rec_nxt.left = head.run_left;
        rec_nxt.top = head.run_top;
        rec_nxt.right = head.run_right;
        rec_nxt.bottom = head.run_bottom;
        rec_nxt.last = 1'b0;
        if (head.frm_vld) begin
          run_sent_nxt = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        rec_nxt.kind = head.frm_kind;
        rec_nxt.left = head.box_left;
        rec_nxt.top = head.box_top;
        rec_nxt.right = head.box_right;
        rec_nxt.bottom = head.box_bottom;
        rec_nxt.last = 1'b1;
        run_sent_nxt = 1'b0;
        q_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      run_sent_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      run_sent_r <= run_sent_nxt;
    end
  end

endmodule

/* sv/color_key_run_extractor_top.sv */
// Color-key run extractor: one 24-bit pixel is taken per clock in raster order, and every
// horizontal run of pixels outside the key range leaves as a run rectangle, followed at the
// end of each frame by the bounding box of all runs or an empty-frame record (tlast high).
// A pixel is taken in the cycle it is offered as long as the four-entry queue between the
// classifier and the record generator has room; records leave one per clock from an output
// register while out_tready is high, and a frame's last pixel may yield two records, which
// the queue absorbs. Write the registers only while idle.
module color_key_run_extractor_top
  import ckre_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // pixel_word
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata,  // rect_left, rect_top, rect_right, rect_bottom
  output logic [KIND_W-1:0]     out_tuser,  // record_kind
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  ckre_cfg_t cfg_r, cfg_nxt;
  logic      cfg_wr;
  logic      q_push, q_pop, q_full, q_empty;
  ckre_cmd_t q_cmd, q_head;
  ckre_rec_t rec;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_KEY:    cfg_nxt.key_color = cfg_pwdata[PIX_W-1:0];
        REG_TOL:    cfg_nxt.tolerance = cfg_pwdata[PIX_W-1:0];
        REG_WIDTH:  cfg_nxt.image_width = cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_nxt.image_height = cfg_pwdata[DIM_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_KEY:    cfg_prdata = {8'd0, cfg_r.key_color};
      REG_TOL:    cfg_prdata = {8'd0, cfg_r.tolerance};
      REG_WIDTH:  cfg_prdata = {{(32 - DIM_W){1'b0}}, cfg_r.image_width};
      REG_HEIGHT: cfg_prdata = {{(32 - DIM_W){1'b0}}, cfg_r.image_height};
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_color <= KEY_RESET;
      cfg_r.tolerance <= TOL_RESET;
      cfg_r.image_width <= WIDTH_RESET;
      cfg_r.image_height <= HEIGHT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ckre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pix_valid (in_tvalid),
    .pix       (in_tdata),
    .q_full    (q_full),
    .pix_ready (in_tready),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  ckre_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  ckre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (q_head),
    .q_pop     (q_pop),
    .rec_ready (out_tready),
    .rec_valid (out_tvalid),
    .rec       (rec)
  );

  assign out_tdata = {4'd0, rec.bottom, rec.right, rec.top, rec.left};
  assign out_tuser = rec.kind;
  assign out_tlast = rec.last;

endmodule
